### rtl/rti_pkg.sv
// Shared constants for the ray/triangle intersection pipeline.
// Field widths, arithmetic widths and status codes; no dependencies.
package rti_pkg;

	localparam int CW     = 16;           // coordinate width, signed Q8.8
	localparam int E_W    = CW + 1;       // differences of two coordinates
	localparam int DIR_W  = 16;           // direction component, Q1.15
	localparam int SQ_W   = 2 * E_W;      // squared length, even width
	localparam int GW     = 3 * E_W + 4;  // determinant and numerators
	localparam int LIM_W  = 16;
	localparam int REG_W  = 3 * CW;
	localparam int DIST_W = 32;
	localparam int T_FRAC = 23;           // fraction bits made by the divider
	localparam int T_QB   = DIST_W - 1;   // quotient bits of the distance divide
	localparam int IN_W   = 6 * CW;
	localparam int OUT_W  = 40;

	localparam logic [DIR_W-1:0]  DIR_MAX  = DIR_W'(32767);
	localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;

	localparam logic [1:0] REG_VA    = 2'd0;
	localparam logic [1:0] REG_VB    = 2'd1;
	localparam logic [1:0] REG_VC    = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_PARALLEL = 3'd1;
	localparam logic [2:0] ST_U_OUT    = 3'd2;
	localparam logic [2:0] ST_V_OUT    = 3'd3;
	localparam logic [2:0] ST_BEHIND   = 3'd4;

endpackage

### rtl/rti_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Carries a sideband word along; no package dependencies.
module rti_sqrt #(
	parameter int IW = 34,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IW-1:0]     in_value,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [IW/2-1:0]   out_root,
	output logic [SW-1:0]     out_side
);
	localparam int RW  = IW / 2;
	localparam int RMW = RW + 3;

	logic            v_s    [RW+1];
	logic [IW-1:0]   n_s    [RW+1];
	logic [RMW-1:0]  rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [SW-1:0]   side_s [RW+1];

	assign v_s[0]    = in_valid;
	assign n_s[0]    = in_value;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RMW-1:0] rem_nx;
		logic           ge;
		always_comb begin
			logic [RMW-1:0] r2;
			logic [RMW-1:0] trial;
			r2     = {rem_s[k][RMW-3:0], n_s[k][IW-1 -: 2]};
			trial  = RMW'({root_s[k], 2'b01});
			ge     = r2 >= trial;
			rem_nx = ge ? r2 - trial : r2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]    <= n_s[k] << 2;
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

### rtl/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Carries a sideband word; no package dependencies.
module rti_div #(
	parameter int LANES = 1,
	parameter int DW    = 8,
	parameter int QB    = 8,
	parameter int SW    = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][DW-1:0]    in_rem,   // partial remainder, below divisor
	input  logic [LANES-1:0][QB-1:0]    in_bits,  // dividend bits still to shift in
	input  logic [DW-1:0]               in_den,
	input  logic [SW-1:0]               in_side,
	output logic                        out_valid,
	output logic [LANES-1:0][QB-1:0]    out_quo,
	output logic [SW-1:0]               out_side
);
	logic                      v_s    [QB+1];
	logic [LANES-1:0][DW-1:0]  rem_s  [QB+1];
	logic [LANES-1:0][QB-1:0]  bits_s [QB+1];
	logic [LANES-1:0][QB-1:0]  quo_s  [QB+1];
	logic [DW-1:0]             den_s  [QB+1];
	logic [SW-1:0]             side_s [QB+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = in_rem;
	assign bits_s[0] = in_bits;
	assign quo_s[0]  = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [LANES-1:0][DW-1:0] rem_nx;
		logic [LANES-1:0]         qbit;
		always_comb begin
			logic [DW:0] r2;
			for (int l = 0; l < LANES; l++) begin
				r2      = {rem_s[k][l], bits_s[k][l][QB-1]};
				qbit[l] = r2 >= {1'b0, den_s[k]};
				rem_nx[l] = qbit[l] ? DW'(r2 - {1'b0, den_s[k]}) : DW'(r2);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					bits_s[k+1][l] <= bits_s[k][l] << 1;
					quo_s[k+1][l]  <= {quo_s[k][l][QB-2:0], qbit[l]};
				end
				rem_s[k+1]  <= rem_nx;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign out_quo   = quo_s[QB];
	assign out_side  = side_s[QB];

endmodule

### rtl/rti_geom.sv
// Moller-Trumbore products: cross products, then the four dot products.
// Three register stages. Depends on rti_pkg.
module rti_geom import rti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [DIR_W-1:0] in_dir [3],
	input  logic signed [E_W-1:0]   in_s   [3],
	input  logic signed [E_W-1:0]   in_e1  [3],
	input  logic signed [E_W-1:0]   in_e2  [3],
	output logic                    out_valid,
	output logic signed [GW-1:0]    out_det,
	output logic signed [GW-1:0]    out_un,
	output logic signed [GW-1:0]    out_vn,
	output logic signed [GW-1:0]    out_tn
);
	localparam int PW = DIR_W + E_W;
	localparam int QW = 2 * E_W;
	localparam int M1 = E_W + PW + 1;
	localparam int M2 = DIR_W + QW + 1;
	localparam int M3 = E_W + QW + 1;

	logic                    v_s1, v_s2, v_s3;
	logic signed [PW-1:0]    pa_s1 [3];
	logic signed [PW-1:0]    pb_s1 [3];
	logic signed [QW-1:0]    qa_s1 [3];
	logic signed [QW-1:0]    qb_s1 [3];
	logic signed [DIR_W-1:0] dir_s1 [3];
	logic signed [E_W-1:0]   s_s1 [3];
	logic signed [PW:0]      p_v [3];
	logic signed [QW:0]      q_v [3];
	logic signed [M1-1:0]    ep_s2 [3];
	logic signed [M1-1:0]    sp_s2 [3];
	logic signed [M2-1:0]    dq_s2 [3];
	logic signed [M3-1:0]    eq_s2 [3];
	logic signed [GW-1:0]    det_s3, un_s3, vn_s3, tn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// P = dir x e2, Q = s x e1, as separate product terms
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= in_dir[1] * in_e2[2];
			pb_s1[0] <= in_dir[2] * in_e2[1];
			pa_s1[1] <= in_dir[2] * in_e2[0];
			pb_s1[1] <= in_dir[0] * in_e2[2];
			pa_s1[2] <= in_dir[0] * in_e2[1];
			pb_s1[2] <= in_dir[1] * in_e2[0];
			qa_s1[0] <= in_s[1] * in_e1[2];
			qb_s1[0] <= in_s[2] * in_e1[1];
			qa_s1[1] <= in_s[2] * in_e1[0];
			qb_s1[1] <= in_s[0] * in_e1[2];
			qa_s1[2] <= in_s[0] * in_e1[1];
			qb_s1[2] <= in_s[1] * in_e1[0];
			dir_s1   <= in_dir;
			s_s1     <= in_s;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_v[k] = (PW+1)'(pa_s1[k]) - (PW+1)'(pb_s1[k]);
			q_v[k] = (QW+1)'(qa_s1[k]) - (QW+1)'(qb_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ep_s2[k] <= in_e1[k] * p_v[k];
				sp_s2[k] <= s_s1[k] * p_v[k];
				dq_s2[k] <= dir_s1[k] * q_v[k];
				eq_s2[k] <= in_e2[k] * q_v[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= GW'(ep_s2[0]) + GW'(ep_s2[1]) + GW'(ep_s2[2]);
			un_s3  <= GW'(sp_s2[0]) + GW'(sp_s2[1]) + GW'(sp_s2[2]);
			vn_s3  <= GW'(dq_s2[0]) + GW'(dq_s2[1]) + GW'(dq_s2[2]);
			tn_s3  <= GW'(eq_s2[0]) + GW'(eq_s2[1]) + GW'(eq_s2[2]);
		end
	end

	assign out_valid = v_s3;
	assign out_det   = det_s3;
	assign out_un    = un_s3;
	assign out_vn    = vn_s3;
	assign out_tn    = tn_s3;

endmodule

### rtl/ray_triangle_intersection.sv
// Ray/triangle intersection pipeline (Moller-Trumbore, fixed point).
// Uses rti_pkg, rti_sqrt, rti_div and rti_geom.
//
// Usage:
//  - Write the three vertices and the parallel limit on the cfg port
//    (cfg_we, cfg_index, cfg_data) while no rays are in flight.
//  - Each beat on s_* is one ray: start point and a second point, Q8.8.
//  - Each beat on m_* is one result: hit flag, status code, Q16.16 distance.
//  - Throughput: one ray per cycle while the pipe is not frozen. Every stage is registered; the long
//    parts are the square root (17 stages), the direction divide
//    (16 stages) and the distance divide (31 stages).
//  - A two-entry output buffer lets rays keep entering while a result waits.
//    When both entries are full and a result reaches the end of the pipe,
//    the whole pipe freezes (s_tready low) until the receiver takes a beat;
//    nothing is dropped or repeated.
//  - Reset clears the pipe and the buffer and loads the reset registers
//    (vertices 0, parallel limit 1).
module ray_triangle_intersection import rti_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [REG_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	// start_x, start_y, start_z, toward_x, toward_y, toward_z
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// hit [0], status [3:1], distance [35:4], zero pad [39:36]
	output logic [OUT_W-1:0]  m_tdata
);
	localparam int SQ_SIDE  = 3 * CW + 3 * E_W;
	localparam int DV_SIDE  = 3 * CW + 4;
	localparam int TD_SIDE  = 5;
	localparam int DIR_FRAC = DIR_W - 1;
	localparam int T_INT    = T_QB - T_FRAC;

	// configuration
	logic [REG_W-1:0] va_q, vb_q, vc_q;
	logic [LIM_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q    <= '0;
			vb_q    <= '0;
			vc_q    <= '0;
			limit_q <= LIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VA:    va_q    <= cfg_data;
				REG_VB:    vb_q    <= cfg_data;
				REG_VC:    vc_q    <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
				default:   ;
			endcase
		end
	end

	logic signed [E_W-1:0] a_e [3];
	logic signed [E_W-1:0] e1 [3];
	logic signed [E_W-1:0] e2 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_e[k] = E_W'($signed(va_q[k*CW +: CW]));
			e1[k]  = E_W'($signed(vb_q[k*CW +: CW])) - a_e[k];
			e2[k]  = E_W'($signed(vc_q[k*CW +: CW])) - a_e[k];
		end
	end

	// global advance; output buffer
	logic             en;
	logic             last_v;
	logic [OUT_W-1:0] last_data;
	logic [1:0]       cnt_q;
	logic [OUT_W-1:0] buf0_q, buf1_q;
	logic             push, pop;

	assign en       = !last_v || (cnt_q != 2'd2);
	assign s_tready = en;
	assign push     = last_v && en;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				buf0_q <= last_data;
			end else begin
				buf0_q <= buf1_q;
				buf1_q <= last_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				buf0_q <= last_data;
			end else begin
				buf1_q <= last_data;
			end
		end else if (pop) begin
			buf0_q <= buf1_q;
		end
	end

	// stage 1: direction vector
	logic                  v_s1, v_s2;
	logic signed [CW-1:0]  st_s1 [3];
	logic signed [E_W-1:0] d_s1 [3];
	logic signed [CW-1:0]  st_s2 [3];
	logic signed [E_W-1:0] d_s2 [3];
	logic [SQ_W-1:0]       sq_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				st_s1[k] <= $signed(s_tdata[k*CW +: CW]);
				d_s1[k]  <= E_W'($signed(s_tdata[(k+3)*CW +: CW]))
				            - E_W'($signed(s_tdata[k*CW +: CW]));
				st_s2[k] <= st_s1[k];
				d_s2[k]  <= d_s1[k];
				sq_s2[k] <= SQ_W'(d_s1[k] * d_s1[k]);
			end
		end
	end

	// length of the direction vector
	logic [SQ_W-1:0]    len_sq;
	logic [SQ_SIDE-1:0] sq_side_in, sq_side_out;
	logic               sq_v;
	logic [E_W-1:0]     len;

	always_comb begin
		len_sq = sq_s2[0] + sq_s2[1] + sq_s2[2];
		for (int k = 0; k < 3; k++) begin
			sq_side_in[k*CW +: CW]            = st_s2[k];
			sq_side_in[3*CW + k*E_W +: E_W]   = d_s2[k];
		end
	end

	rti_sqrt #(
		.IW (SQ_W),
		.SW (SQ_SIDE)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_value  (len_sq),
		.in_side   (sq_side_in),
		.out_valid (sq_v),
		.out_root  (len),
		.out_side  (sq_side_out)
	);

	// normalize: |d| * 2^15 / len per component
	logic [2:0][E_W-1:0]   dv_rem;
	logic [2:0][DIR_W-1:0] dv_bits;
	logic [DV_SIDE-1:0]    dv_side_in, dv_side_out;
	logic                  dv_v;
	logic [2:0][DIR_W-1:0] dv_quo;

	always_comb begin
		logic signed [E_W-1:0] dk;
		logic [E_W-1:0]        mag;
		dv_side_in[3*CW+3] = len == '0;
		for (int k = 0; k < 3; k++) begin
			dk  = $signed(sq_side_out[3*CW + k*E_W +: E_W]);
			mag = dk[E_W-1] ? E_W'(-dk) : E_W'(dk);
			dv_rem[k]  = mag >> 1;
			dv_bits[k] = {mag[0], DIR_FRAC'(0)};
			dv_side_in[k*CW +: CW] = sq_side_out[k*CW +: CW];
			dv_side_in[3*CW + k]   = dk[E_W-1];
		end
	end

	rti_div #(
		.LANES (3),
		.DW    (E_W),
		.QB    (DIR_W),
		.SW    (DV_SIDE)
	) u_dir_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.in_rem    (dv_rem),
		.in_bits   (dv_bits),
		.in_den    (len),
		.in_side   (dv_side_in),
		.out_valid (dv_v),
		.out_quo   (dv_quo),
		.out_side  (dv_side_out)
	);

	// stage 3: signed direction and start relative to vertex a
	logic                    v_s3;
	logic signed [DIR_W-1:0] dir_s3 [3];
	logic signed [E_W-1:0]   s_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		logic [DIR_W-1:0] m;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (dv_side_out[3*CW+3]) begin
					m = '0;
				end else if (dv_quo[k] > DIR_MAX) begin
					m = DIR_MAX;
				end else begin
					m = dv_quo[k];
				end
				dir_s3[k] <= dv_side_out[3*CW + k] ? $signed(-m) : $signed(m);
				s_s3[k]   <= E_W'($signed(dv_side_out[k*CW +: CW])) - a_e[k];
			end
		end
	end

	logic                 g_v;
	logic signed [GW-1:0] g_det, g_un, g_vn, g_tn;

	rti_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_dir    (dir_s3),
		.in_s      (s_s3),
		.in_e1     (e1),
		.in_e2     (e2),
		.out_valid (g_v),
		.out_det   (g_det),
		.out_un    (g_un),
		.out_vn    (g_vn),
		.out_tn    (g_tn)
	);

	// stage 4: fold the determinant sign into the numerators
	logic                 v_s4, neg_s4, par_s4;
	logic [GW-1:0]        dm_s4;
	logic signed [GW-1:0] un_s4, vn_s4, tn_s4;
	logic                 neg_g;
	logic [GW-1:0]        dm_g;

	assign neg_g = g_det[GW-1];
	assign dm_g  = neg_g ? GW'(-g_det) : GW'(g_det);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= g_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4 <= neg_g;
			dm_s4  <= dm_g;
			par_s4 <= (g_det == '0) || (dm_g < GW'(limit_q));
			un_s4  <= neg_g ? -g_un : g_un;
			vn_s4  <= neg_g ? -g_vn : g_vn;
			tn_s4  <= neg_g ? -g_tn : g_tn;
		end
	end

	// stage 5: range tests on the numerators, overflow check of t
	logic              v_s5, neg_s5, ovf_s5;
	logic [2:0]        status_s5;
	logic [GW-1:0]     dm_s5, num_s5;
	logic [2:0]        status_c;
	logic signed [GW:0] uv;

	always_comb begin
		uv = (GW+1)'(un_s4) + (GW+1)'(vn_s4);
		if (par_s4) begin
			status_c = ST_PARALLEL;
		end else if (un_s4 < 0 || un_s4 > $signed(dm_s4)) begin
			status_c = ST_U_OUT;
		end else if (vn_s4 < 0 || uv < 0 || uv > $signed({1'b0, dm_s4})) begin
			status_c = ST_V_OUT;
		end else if (tn_s4 < 0) begin
			status_c = ST_BEHIND;
		end else begin
			status_c = ST_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5    <= neg_s4;
			status_s5 <= status_c;
			dm_s5     <= dm_s4;
			num_s5    <= GW'(tn_s4);
			// t would need more than the integer bits of Q16.16
			ovf_s5    <= (GW'(tn_s4) >> T_INT) >= dm_s4;
		end
	end

	// t = tn / |det| in Q16.16
	logic [0:0][GW-1:0]   td_rem;
	logic [0:0][T_QB-1:0] td_bits;
	logic [TD_SIDE-1:0]   td_side_out;
	logic                 td_v;
	logic [0:0][T_QB-1:0] td_quo;

	assign td_rem[0]  = num_s5 >> T_INT;
	assign td_bits[0] = {num_s5[T_INT-1:0], T_FRAC'(0)};

	rti_div #(
		.LANES (1),
		.DW    (GW),
		.QB    (T_QB),
		.SW    (TD_SIDE)
	) u_dist_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_rem    (td_rem),
		.in_bits   (td_bits),
		.in_den    (dm_s5),
		.in_side   ({ovf_s5, neg_s5, status_s5}),
		.out_valid (td_v),
		.out_quo   (td_quo),
		.out_side  (td_side_out)
	);

	always_comb begin
		logic [DIST_W-1:0] t;
		logic [DIST_W-1:0] dist_out;
		logic              hit;
		t        = td_side_out[4] ? DIST_MAX : {1'b0, td_quo[0]};
		hit      = td_side_out[2:0] == ST_HIT;
		dist_out = !hit ? '0 : (td_side_out[3] ? -t : t);
		last_v    = td_v;
		last_data = {(OUT_W-DIST_W-4)'(0), dist_out, td_side_out[2:0], hit};
	end

endmodule
